// ===== sv/tlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tlfs_pkg: shared types and constants of the two-level feedback scheduler
// Payload structs, action codes, register indexes, sequencer states and
// the ALU operation codes.
// ----------------------------------------------------------------------------
package tlfs_pkg;

  localparam int TID_W        = 4;
  localparam int ACT_W        = 3;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int ELAPSED_W    = 17;
  localparam int MAX_THREADS_DEF = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Register reset values
  localparam logic [CFG_W-1:0] FIRST_QUANTUM_RST  = 16'd4;
  localparam logic [CFG_W-1:0] SECOND_QUANTUM_RST = 16'd8;
  localparam logic [CFG_W-1:0] TICK_INTERVAL_RST  = 16'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_QUANTUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_QUANTUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_INTERVAL  = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK       = 3'd0,
    ACT_ADD_READY  = 3'd1,
    ACT_FINISH     = 3'd2,
    ACT_BLOCK      = 3'd3,
    ACT_NOTIFY_ONE = 3'd4,
    ACT_NOTIFY_ALL = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_CMP,
    S_DISP_RD,
    S_DISP_POP,
    S_MOVE_RD,
    S_MOVE,
    S_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD_SAT,
    ALU_CMP_GE
  } alu_op_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [TID_W-1:0] thread_id;
  } sched_in_t;

  typedef struct packed {
    logic [TID_W-1:0] running_id;
    logic             running_valid;
    logic             running_level;
    logic             overflow;
  } sched_out_t;

  // FIFO control from the sequencer and status back to it
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;   // exactly one entry held
  } fifo_sts_t;

endpackage

// ===== sv/tlfs_ram.sv =====
// ----------------------------------------------------------------------------
// tlfs_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module tlfs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tlfs_fifo.sv =====
// ----------------------------------------------------------------------------
// tlfs_fifo: circular FIFO of thread identifiers
// Head pointer and fill count around one RAM. The RAM is read at the head
// continuously; head data is good in the cycle after the head settles.
// A push into a full FIFO is dropped.
// ----------------------------------------------------------------------------
module tlfs_fifo #(
  parameter int DEPTH = tlfs_pkg::MAX_THREADS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlfs_pkg::fifo_ctl_t          ctl,
  input  logic [tlfs_pkg::TID_W-1:0]   push_data,
  output tlfs_pkg::fifo_sts_t          sts,
  output logic [tlfs_pkg::TID_W-1:0]   head_data
);
  import tlfs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic          do_push;

  // head + count stays below twice the depth: one compare and subtract
  always_comb begin
    tail_sum = {1'b0, CW'(head_r)} + {1'b0, count_r};
    if (tail_sum >= (CW+1)'(DEPTH)) begin
      tail_sum = tail_sum - (CW+1)'(DEPTH);
    end
    tail = tail_sum[AW-1:0];
  end

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));
  assign sts.last  = (count_r == CW'(1));
  assign do_push   = ctl.push && !sts.full;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.pop && !sts.empty) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end else if (do_push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  tlfs_ram #(
    .WIDTH (TID_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (tail),
    .wdata (push_data),
    .raddr (head_r),
    .rdata (head_data)
  );

endmodule

// ===== sv/tlfs_alu.sv =====
// ----------------------------------------------------------------------------
// tlfs_alu: shared elapsed-time unit
// Saturating add of the tick interval, or compare against the quantum.
// ----------------------------------------------------------------------------
module tlfs_alu (
  input  tlfs_pkg::alu_op_t                 op,
  input  logic [tlfs_pkg::ELAPSED_W-1:0]    a,
  input  logic [tlfs_pkg::CFG_W-1:0]        b,
  output logic [tlfs_pkg::ELAPSED_W-1:0]    res,
  output logic                              ge
);
  import tlfs_pkg::*;

  logic [ELAPSED_W:0] sum;

  always_comb begin
    sum = {1'b0, a} + (ELAPSED_W+1)'(b);
    res = a;
    ge  = 1'b0;
    unique case (op)
      ALU_ADD_SAT: res = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
      ALU_CMP_GE:  ge  = (a >= ELAPSED_W'(b));
      default:     res = a;
    endcase
  end

endmodule

// ===== sv/two_level_feedback_scheduler.sv =====
// ----------------------------------------------------------------------------
// two_level_feedback_scheduler: two-level feedback thread scheduler
// High and low ready FIFOs, a blocked FIFO and the running thread, stepped
// by scheduler events under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Event channel: drive in_data and raise start; the event transfers at a
//   clock edge with start high and busy low. busy stays high until the
//   result has been shown.
//   Result channel: out_valid strobes for one cycle with out_data (running
//   thread, level, overflow). The receiver cannot stall it.
//   Config channel: cfg_index/cfg_data transfer when cfg_valid and cfg_ready
//   are high; cfg_ready is always high. Write only while busy is low.
// State path from the transfer edge to the strobe in S_DONE:
//   add ready, idle finish/block, nothing to notify, unused codes: DECODE
//   other finish/block, idle or preempting tick: DECODE, DISP_RD, DISP_POP
//   tick with advance: DECODE, ADD, CMP (+ DISP_RD, DISP_POP on expiry)
//   notify one: DECODE, MOVE_RD, MOVE; all: DECODE, MOVE_RD, MOVE per entry
//   One event at a time; the next may transfer the cycle after the strobe.
//   The registered head reads of the FIFO RAMs split each pop into a read
//   and a pop state; the shared ALU adds and compares in separate cycles.
// Reset: synchronous, rst_n low. Idle, all FIFOs empty, registers to
//   4 / 8 / 1. No memory clearing pass.
// ----------------------------------------------------------------------------
module two_level_feedback_scheduler #(
  parameter int MAX_THREADS = tlfs_pkg::MAX_THREADS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // event channel
  input  logic                              start,
  output logic                              busy,
  input  tlfs_pkg::sched_in_t               in_data,
  // result channel
  output logic                              out_valid,
  output tlfs_pkg::sched_out_t              out_data,
  // config channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlfs_pkg::CFG_W-1:0]        cfg_data
);
  import tlfs_pkg::*;

  state_t               state_r, state_nxt;
  logic [ACT_W-1:0]     act_r, act_nxt;
  logic [TID_W-1:0]     tid_r, tid_nxt;
  logic [TID_W-1:0]     run_id_r, run_id_nxt;
  logic                 run_valid_r, run_valid_nxt;
  logic                 run_level_r, run_level_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 ovf_r, ovf_nxt;

  // configuration registers
  logic [CFG_W-1:0]     fq_r, sq_r, ti_r;

  // FIFO hookup
  fifo_ctl_t            hi_ctl, lo_ctl, bk_ctl;
  fifo_sts_t            hi_sts, lo_sts, bk_sts;
  logic [TID_W-1:0]     hi_wdata;
  logic [TID_W-1:0]     hi_data, lo_data, bk_data;

  // shared ALU
  alu_op_t              alu_op;
  logic [CFG_W-1:0]     alu_b;
  logic [ELAPSED_W-1:0] alu_res;
  logic                 alu_ge;

  assign alu_b = (alu_op == ALU_ADD_SAT) ? ti_r : (run_level_r ? sq_r : fq_r);

  tlfs_alu u_alu (
    .op  (alu_op),
    .a   (elapsed_r),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge)
  );

  tlfs_fifo #(.DEPTH(MAX_THREADS)) u_hi_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hi_ctl),
    .push_data (hi_wdata),
    .sts       (hi_sts),
    .head_data (hi_data)
  );

  // low FIFO and blocked FIFO only ever take the running thread
  tlfs_fifo #(.DEPTH(MAX_THREADS)) u_lo_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lo_ctl),
    .push_data (run_id_r),
    .sts       (lo_sts),
    .head_data (lo_data)
  );

  tlfs_fifo #(.DEPTH(MAX_THREADS)) u_bk_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (bk_ctl),
    .push_data (run_id_r),
    .sts       (bk_sts),
    .head_data (bk_data)
  );

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    tid_nxt       = tid_r;
    run_id_nxt    = run_id_r;
    run_valid_nxt = run_valid_r;
    run_level_nxt = run_level_r;
    elapsed_nxt   = elapsed_r;
    ovf_nxt       = ovf_r;
    hi_ctl        = '0;
    lo_ctl        = '0;
    bk_ctl        = '0;
    hi_wdata      = (state_r == S_MOVE) ? bk_data : tid_r;
    alu_op        = ALU_CMP_GE;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt   = in_data.action;
          tid_nxt   = in_data.thread_id;
          ovf_nxt   = 1'b0;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (act_r)
          ACT_TICK: begin
            priority if (!run_valid_r) begin
              state_nxt = S_DISP_RD;
            end else if (run_level_r && !hi_sts.empty) begin
              // preempt level-1 runner; dispatch then takes the high head
              lo_ctl.push   = 1'b1;
              ovf_nxt       = ovf_r | lo_sts.full;
              run_valid_nxt = 1'b0;
              run_id_nxt    = '0;
              run_level_nxt = 1'b0;
              elapsed_nxt   = '0;
              state_nxt     = S_DISP_RD;
            end else begin
              state_nxt = S_ADD;
            end
          end
          ACT_ADD_READY: begin
            hi_ctl.push = 1'b1;
            ovf_nxt     = ovf_r | hi_sts.full;
          end
          ACT_FINISH: begin
            if (run_valid_r) begin
              run_valid_nxt = 1'b0;
              run_id_nxt    = '0;
              run_level_nxt = 1'b0;
              elapsed_nxt   = '0;
              state_nxt     = S_DISP_RD;
            end
          end
          ACT_BLOCK: begin
            if (run_valid_r) begin
              bk_ctl.push   = 1'b1;
              ovf_nxt       = ovf_r | bk_sts.full;
              run_valid_nxt = 1'b0;
              run_id_nxt    = '0;
              run_level_nxt = 1'b0;
              elapsed_nxt   = '0;
              state_nxt     = S_DISP_RD;
            end
          end
          ACT_NOTIFY_ONE, ACT_NOTIFY_ALL: begin
            if (!bk_sts.empty) begin
              state_nxt = S_MOVE_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_ADD: begin
        alu_op      = ALU_ADD_SAT;
        elapsed_nxt = alu_res;
        state_nxt   = S_CMP;
      end

      S_CMP: begin
        alu_op = ALU_CMP_GE;
        if (alu_ge) begin
          // quantum used up: demote and dispatch
          lo_ctl.push   = 1'b1;
          ovf_nxt       = ovf_r | lo_sts.full;
          run_valid_nxt = 1'b0;
          run_id_nxt    = '0;
          run_level_nxt = 1'b0;
          elapsed_nxt   = '0;
          state_nxt     = S_DISP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DISP_RD: begin
        state_nxt = S_DISP_POP;
      end

      S_DISP_POP: begin
        priority if (!hi_sts.empty) begin
          hi_ctl.pop    = 1'b1;
          run_id_nxt    = hi_data;
          run_valid_nxt = 1'b1;
          run_level_nxt = 1'b0;
          elapsed_nxt   = '0;
        end else if (!lo_sts.empty) begin
          lo_ctl.pop    = 1'b1;
          run_id_nxt    = lo_data;
          run_valid_nxt = 1'b1;
          run_level_nxt = 1'b1;
          elapsed_nxt   = '0;
        end else begin
          run_valid_nxt = 1'b0;
        end
        state_nxt = S_DONE;
      end

      S_MOVE_RD: begin
        state_nxt = S_MOVE;
      end

      S_MOVE: begin
        // blocked head to high FIFO; lost if high is full
        bk_ctl.pop  = 1'b1;
        hi_ctl.push = 1'b1;
        ovf_nxt     = ovf_r | hi_sts.full;
        if (act_r == ACT_NOTIFY_ALL && !bk_sts.last) begin
          state_nxt = S_MOVE_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_id_r    <= '0;
      run_valid_r <= 1'b0;
      run_level_r <= 1'b0;
      elapsed_r   <= '0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_id_r    <= run_id_nxt;
      run_valid_r <= run_valid_nxt;
      run_level_r <= run_level_nxt;
      elapsed_r   <= elapsed_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // event payload latch, no reset needed
  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    tid_r <= tid_nxt;
  end

  // configuration registers; writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fq_r <= FIRST_QUANTUM_RST;
      sq_r <= SECOND_QUANTUM_RST;
      ti_r <= TICK_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRST_QUANTUM:  fq_r <= cfg_data;
        CFG_SECOND_QUANTUM: sq_r <= cfg_data;
        CFG_TICK_INTERVAL:  ti_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // result strobe straight from registers
  assign busy                   = (state_r != S_IDLE);
  assign out_valid              = (state_r == S_DONE);
  assign out_data.running_id    = run_valid_r ? run_id_r : '0;
  assign out_data.running_valid = run_valid_r;
  assign out_data.running_level = run_valid_r & run_level_r;
  assign out_data.overflow      = ovf_r;

`ifndef SYNTH
  // every result ends the event: ready for the next one right after
  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy still high after result strobe");

  // an accepted event always occupies the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("event transfer did not start the sequencer");

  // a freshly dispatched thread starts with a clear counter
  a_dispatch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == S_DISP_POP) && run_valid_r |-> elapsed_r == '0)
    else $error("dispatched thread has nonzero elapsed time");

  // a pop never targets an empty blocked FIFO
  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> !bk_sts.empty)
    else $error("move from empty blocked FIFO");
`endif

endmodule
